// ===== hdl/rwfs_pkg.sv =====
package rwfs_pkg;

	localparam int unsigned POS_W      = 4;
	localparam int unsigned HEADER_LEN = 12;
	localparam int unsigned CHDR_LEN   = 8;
	localparam int unsigned FMT_LEN    = 16;
	localparam int unsigned ID_LEN     = 4;
	localparam logic [31:0] FMT_ID     = 32'h2074_6D66;
	localparam logic [31:0] LEN_STOP   = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_CHDR,
		PH_SKIP,
		PH_FMT,
		PH_FOUND,
		PH_STOPPED,
		PH_NOTWAVE
	} phase_t;

	typedef struct packed {
		logic       take;
		logic       last;
		logic [7:0] data;
	} step_t;

	typedef struct packed {
		logic        is_wave;
		logic        fmt_found;
		logic [15:0] fmt_code;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [POS_W-1:0] pos);
		logic [7:0] m;
		case (pos)
			4'd0:    m = 8'h52;
			4'd1:    m = 8'h49;
			4'd2:    m = 8'h46;
			4'd3:    m = 8'h46;
			4'd8:    m = 8'h57;
			4'd9:    m = 8'h41;
			4'd10:   m = 8'h56;
			4'd11:   m = 8'h45;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

// ===== hdl/rwfs_byte_if.sv =====
interface rwfs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;

	modport source (output valid, output payload_byte, output last_byte, input ready);
	modport sink (input valid, input payload_byte, input last_byte, output ready);
endinterface

// ===== hdl/rwfs_result_if.sv =====
interface rwfs_result_if;
	logic        valid;
	logic        ready;
	logic        is_wave;
	logic        fmt_found;
	logic [15:0] fmt_code;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;

	modport source (
		output valid, output is_wave, output fmt_found, output fmt_code,
		output channel_count, output rate_hz, input ready
	);
	modport sink (
		input valid, input is_wave, input fmt_found, input fmt_code,
		input channel_count, input rate_hz, output ready
	);
endinterface

// ===== hdl/rwfs_parser.sv =====
module rwfs_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  rwfs_pkg::step_t st,
	output rwfs_pkg::res_t  res,
	output logic           idle
);
	import rwfs_pkg::*;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic               magic_ok_q, magic_ok_d;
	logic               mnext;
	logic [31:0]        chunk_id_q, chunk_id_d;
	logic [31:0]        chunk_len_q, chunk_len_d;
	logic [32:0]        skip_q, skip_d;
	logic [15:0]        tag_q, tag_d;
	logic [15:0]        chan_q, chan_d;
	logic [31:0]        rate_q, rate_d;
	logic               found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			magic_ok_q <= 1'b1;
		end else if (st.take) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			magic_ok_q <= magic_ok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (st.take) begin
			chunk_id_q  <= chunk_id_d;
			chunk_len_q <= chunk_len_d;
			skip_q      <= skip_d;
			tag_q       <= tag_d;
			chan_q      <= chan_d;
			rate_q      <= rate_d;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		magic_ok_d  = magic_ok_q;
		mnext       = magic_ok_q;
		chunk_id_d  = chunk_id_q;
		chunk_len_d = chunk_len_q;
		skip_d      = skip_q;
		tag_d       = tag_q;
		chan_d      = chan_q;
		rate_d      = rate_q;
		case (phase_q)
			PH_HEADER: begin
				if ((pos_q < POS_W'(ID_LEN) || pos_q >= POS_W'(CHDR_LEN))
						&& st.data != magic_byte(pos_q)) begin
					mnext = 1'b0;
				end
				magic_ok_d = mnext;
				pos_d      = pos_q + POS_W'(1);
				if (pos_q == POS_W'(HEADER_LEN - 1)) begin
					pos_d   = '0;
					phase_d = mnext ? PH_CHDR : PH_NOTWAVE;
				end
			end
			PH_CHDR: begin
				if (pos_q < POS_W'(ID_LEN)) begin
					chunk_id_d = {st.data, chunk_id_q[31:8]};
				end else begin
					chunk_len_d = {st.data, chunk_len_q[31:8]};
				end
				pos_d = pos_q + POS_W'(1);
				if (pos_q == POS_W'(CHDR_LEN - 1)) begin
					pos_d = '0;
					if (chunk_id_d == FMT_ID) begin
						phase_d = PH_FMT;
					end else if (chunk_len_d == LEN_STOP) begin
						phase_d = PH_STOPPED;
					end else begin
						skip_d  = {1'b0, chunk_len_d} + {32'd0, chunk_len_d[0]};
						phase_d = (chunk_len_d == '0) ? PH_CHDR : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 33'd1;
				if (skip_q == 33'd1) begin
					phase_d = PH_CHDR;
					pos_d   = '0;
				end
			end
			PH_FMT: begin
				if (pos_q < POS_W'(2)) begin
					tag_d = {st.data, tag_q[15:8]};
				end else if (pos_q < POS_W'(4)) begin
					chan_d = {st.data, chan_q[15:8]};
				end else if (pos_q < POS_W'(8)) begin
					rate_d = {st.data, rate_q[31:8]};
				end
				pos_d = pos_q + POS_W'(1);
				if (pos_q == POS_W'(FMT_LEN - 1)) begin
					pos_d   = '0;
					phase_d = PH_FOUND;
				end
			end
			default: begin
			end
		endcase

		found             = (phase_d == PH_FOUND);
		res.is_wave       = (phase_d != PH_HEADER) && (phase_d != PH_NOTWAVE);
		res.fmt_found     = found;
		res.fmt_code      = found ? tag_d : '0;
		res.channel_count = found ? chan_d : '0;
		res.rate_hz       = found ? rate_d : '0;

		// drop back to the start of a payload after its final word
		if (st.last) begin
			phase_d    = PH_HEADER;
			pos_d      = '0;
			magic_ok_d = 1'b1;
		end
	end

	assign idle = (phase_q == PH_HEADER) && (pos_q == '0) && magic_ok_q;

endmodule

// ===== hdl/riff_wave_format_sniffer_unit.sv =====
// Sniffs a RIFF/WAVE payload streamed one byte per word, with last_byte on the final
// byte, and returns one result word per payload: magic check, fmt chunk found, and the
// format tag, channel count and sample rate (zero when no complete fmt chunk was seen).
// Accepts one byte every clock; a byte is registered, then the combinational chunk-walk
// logic updates the parser state and, for a final byte, loads the result register, from
// which the result is offered. Input only stalls when a final byte meets an untaken
// result register.
module riff_wave_format_sniffer_unit (
	input logic         clk,
	input logic         arst_n,
	rwfs_byte_if.sink   data,
	rwfs_result_if.source result
);
	import rwfs_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res_c;
	step_t      st;
	logic       parser_idle;

	assign advance    = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign data.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data.valid && data.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data.valid && data.ready) begin
			byte_s1 <= data.payload_byte;
			last_s1 <= data.last_byte;
		end
	end

	assign st = '{take: advance, last: last_s1, data: byte_s1};

	rwfs_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.res    (res_c),
		.idle   (parser_idle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res_c;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.is_wave       = res_q.is_wave;
	assign result.fmt_found     = res_q.fmt_found;
	assign result.fmt_code      = res_q.fmt_code;
	assign result.channel_count = res_q.channel_count;
	assign result.rate_hz       = res_q.rate_hz;

`ifndef SYNTH
	a_found_needs_wave: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!result.fmt_found || result.is_wave))
		else $error("fmt_found without wave magic");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.fmt_found) |->
		(result.fmt_code == '0 && result.channel_count == '0 && result.rate_hz == '0))
		else $error("fields nonzero without fmt chunk");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !data.ready)
		else $error("input taken while stage is stalled");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> parser_idle)
		else $error("parser did not restart after final word");
`endif

endmodule

// ===== test/riff_wave_format_sniffer_unit_tb.sv =====
`timescale 1ns / 100ps

module riff_wave_format_sniffer_unit_tb;
	import rwfs_pkg::*;

	localparam logic [95:0] WAV_MAGIC = {"RIFF", 32'h0, "WAVE"};
	localparam logic [31:0] FMT_WORD  = 32'h2074_6D66;
	localparam logic [31:0] STOP_LEN  = 32'hFFFF_FFFF;
	localparam logic [31:0] NO_CHUNK  = 32'h0;
	localparam res_t NOT_WAV    = '0;
	localparam res_t WAV_NO_FMT = '{1'b1, 1'b0, 16'h0, 16'h0, 32'h0};

	typedef struct {
		logic [31:0] riff;
		logic [31:0] wave;
		logic [31:0] pre_id;
		logic [31:0] pre_len;
		logic [31:0] id;
		logic [31:0] len;
		logic [15:0] tag;
		logic [15:0] chans;
		logic [31:0] rate;
		int          extra;
		int          cut;
		bit          known;
		res_t        exp;
	} wav_case_t;

	wav_case_t wav_cases [18] = '{
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 1, 1, NOT_WAV},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 11, 1, NOT_WAV},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 12, 1, WAV_NO_FMT},
		'{"RIFX", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 0, 1, NOT_WAV},
		'{"RIFF", "WAVF", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 0, 1, NOT_WAV},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 0, 1,
			'{1'b1, 1'b1, 16'h1, 16'h2, 32'd44100}},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 1,
			'{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h0, 16'h0, 32'h0, 0, 0, 1,
			'{1'b1, 1'b1, 16'h0, 16'h0, 32'h0}},
		'{"RIFF", "WAVE", "LIST", 3, "fmt ", 16, 16'h3, 16'h1, 8000, 0, 0, 0, NOT_WAV},
		'{"RIFF", "WAVE", "JUNK", 0, "fmt ", 16, 16'hFFFE, 16'h8, 96000, 0, 0, 1,
			'{1'b1, 1'b1, 16'hFFFE, 16'h8, 32'd96000}},
		'{"RIFF", "WAVE", "data", STOP_LEN, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 0, 1,
			WAV_NO_FMT},
		'{"RIFF", "WAVE", "data", 1000, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 0, 0, NOT_WAV},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 2, 16'h1, 16'h1, 22050, 0, 0, 1,
			'{1'b1, 1'b1, 16'h1, 16'h1, 32'd22050}},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", STOP_LEN, 16'h3, 16'h2, 48000, 0, 0, 1,
			'{1'b1, 1'b1, 16'h3, 16'h2, 32'd48000}},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h55AA, 16'hAA55, 32'h1234_5678, 9, 0, 1,
			'{1'b1, 1'b1, 16'h55AA, 16'hAA55, 32'h1234_5678}},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 30, 1, WAV_NO_FMT},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "fmt ", 16, 16'h1, 16'h2, 44100, 0, 17, 1, WAV_NO_FMT},
		'{"RIFF", "WAVE", NO_CHUNK, 0, "FMT ", 16, 16'h1, 16'h2, 44100, 0, 0, 1, WAV_NO_FMT}
	};

	logic clk;
	logic arst_n;

	rwfs_byte_if   byte_ch ();
	rwfs_result_if res_ch ();

	riff_wave_format_sniffer_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.data  (byte_ch),
		.result(res_ch)
	);

	int idle_pct;
	int stall_pct;
	int errors;

	logic [7:0] payload [$];
	res_t       pending_results [$];
	res_t       seen_res;
	res_t       want_res;

	phase_t      sn_phase = PH_HEADER;
	logic [4:0]  sn_pos = '0;
	logic        sn_magic_ok = 1'b1;
	logic [31:0] sn_id = '0;
	logic [31:0] sn_len = '0;
	logic [32:0] sn_skip = '0;
	logic [15:0] sn_tag = '0;
	logic [15:0] sn_chans = '0;
	logic [31:0] sn_rate = '0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic sniff_byte(input logic [7:0] b, input logic fin, output bit done,
			output res_t r);
		logic found;
		case (sn_phase)
			PH_HEADER: begin
				if ((sn_pos < 4 || sn_pos >= 8) && b != WAV_MAGIC[95 - 8 * sn_pos -: 8])
					sn_magic_ok = 1'b0;
				sn_pos++;
				if (sn_pos >= 12) begin
					sn_pos = '0;
					sn_phase = sn_magic_ok ? PH_CHDR : PH_NOTWAVE;
				end
			end
			PH_CHDR: begin
				if (sn_pos < 4)
					sn_id = (sn_pos == 0) ? {24'h0, b} : sn_id | ({24'h0, b} << (8 * sn_pos));
				else
					sn_len = (sn_pos == 4) ? {24'h0, b}
						: sn_len | ({24'h0, b} << (8 * (sn_pos - 4)));
				sn_pos++;
				if (sn_pos >= 8) begin
					sn_pos = '0;
					if (sn_id == FMT_WORD) begin
						sn_phase = PH_FMT;
					end else if (sn_len == STOP_LEN) begin
						sn_phase = PH_STOPPED;
					end else begin
						sn_skip = {1'b0, sn_len} + {32'h0, sn_len[0]};
						sn_phase = (sn_skip == 0) ? PH_CHDR : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (sn_skip > 0)
					sn_skip--;
				if (sn_skip == 0) begin
					sn_phase = PH_CHDR;
					sn_pos = '0;
				end
			end
			PH_FMT: begin
				if (sn_pos < 2)
					sn_tag[8 * sn_pos +: 8] = b;
				else if (sn_pos < 4)
					sn_chans[8 * (sn_pos - 2) +: 8] = b;
				else if (sn_pos < 8)
					sn_rate[8 * (sn_pos - 4) +: 8] = b;
				sn_pos++;
				if (sn_pos >= 16) begin
					sn_pos = '0;
					sn_phase = PH_FOUND;
				end
			end
			default: ;
		endcase
		done = fin;
		r = '0;
		if (fin) begin
			found = (sn_phase == PH_FOUND);
			r.is_wave = (sn_phase != PH_HEADER) && (sn_phase != PH_NOTWAVE);
			r.fmt_found = found;
			if (found) begin
				r.fmt_code = sn_tag;
				r.channel_count = sn_chans;
				r.rate_hz = sn_rate;
			end
			sn_phase = PH_HEADER;
			sn_pos = '0;
			sn_magic_ok = 1'b1;
			sn_id = '0;
			sn_len = '0;
			sn_skip = '0;
			sn_tag = '0;
			sn_chans = '0;
			sn_rate = '0;
		end
	endtask

	task automatic append_byte(input logic [7:0] b);
		payload = {payload, b};
	endtask

	task automatic push_le(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			append_byte(w[8 * k +: 8]);
	endtask

	task automatic push_id(input logic [31:0] s);
		for (int k = 3; k >= 0; k--)
			append_byte(s[8 * k +: 8]);
	endtask

	task automatic build_case(input wav_case_t c);
		int body;
		payload.delete();
		push_id(c.riff);
		push_le($urandom);
		push_id(c.wave);
		if (c.pre_id != NO_CHUNK) begin
			push_id(c.pre_id);
			push_le(c.pre_len);
			body = (c.pre_len <= 64) ? int'(c.pre_len + c.pre_len[0]) : 8;
			repeat (body)
				append_byte(8'($urandom));
		end
		push_id(c.id);
		push_le(c.len);
		append_byte(c.tag[7:0]);
		append_byte(c.tag[15:8]);
		append_byte(c.chans[7:0]);
		append_byte(c.chans[15:8]);
		push_le(c.rate);
		for (int k = 0; k < 8; k++)
			append_byte(8'h5A + 8'(k));
		repeat (c.extra)
			append_byte(8'($urandom));
		if (c.cut > 0)
			payload = payload[0:c.cut - 1];
	endtask

	task automatic make_random_payload();
		int kind;
		int sel;
		int idx;
		int body;
		logic [31:0] id;
		logic [31:0] len;
		payload.delete();
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 20))
				append_byte(8'($urandom));
			return;
		end
		push_id("RIFF");
		push_le($urandom);
		push_id("WAVE");
		if (kind < 16) begin
			idx = $urandom_range(7);
			if (idx >= 4)
				idx += 4;
			payload[idx] = payload[idx] ^ 8'($urandom_range(1, 255));
		end
		repeat ($urandom_range(3)) begin
			sel = $urandom_range(99);
			id = (sel < 45) ? "fmt " : (sel < 60) ? "data" : (sel < 70) ? "LIST" : $urandom;
			sel = $urandom_range(99);
			len = (sel < 60) ? $urandom_range(24) : (sel < 70) ? 32'd16
				: (sel < 80) ? STOP_LEN : $urandom;
			push_id(id);
			push_le(len);
			if (id == FMT_WORD)
				body = ($urandom_range(99) < 85) ? 16 : $urandom_range(15);
			else
				body = (len <= 40) ? int'(len + len[0]) : $urandom_range(8);
			repeat (body)
				append_byte(8'($urandom));
		end
		if ($urandom_range(99) < 20)
			repeat ($urandom_range(1, 4))
				append_byte(8'($urandom));
		if ($urandom_range(99) < 15)
			payload = payload[0:$urandom_range(1, payload.size()) - 1];
	endtask

	task automatic send_payload(input bit known, input res_t exp);
		bit   done;
		res_t r;
		logic fin;
		for (int k = 0; k < payload.size(); k++) begin
			fin = (k == payload.size() - 1);
			while ($urandom_range(99) < idle_pct) begin
				byte_ch.valid <= 1'b0;
				@(posedge clk);
			end
			byte_ch.valid <= 1'b1;
			byte_ch.payload_byte <= payload[k];
			byte_ch.last_byte <= fin;
			@(posedge clk);
			while (!byte_ch.ready)
				@(posedge clk);
			sniff_byte(payload[k], fin, done, r);
			if (done)
				pending_results = {pending_results, (known ? exp : r)};
		end
	endtask

	always @(posedge clk)
		res_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			seen_res = '{res_ch.is_wave, res_ch.fmt_found, res_ch.fmt_code,
				res_ch.channel_count, res_ch.rate_hz};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: wave=%0b fmt=%0b tag=%h ch=%h rate=%h",
						seen_res.is_wave, seen_res.fmt_found, seen_res.fmt_code,
						seen_res.channel_count, seen_res.rate_hz);
			end else begin
				want_res = pending_results.pop_front();
				if (seen_res !== want_res) begin
					errors++;
					if (errors <= 10)
						$display({"result mismatch: exp wave=%0b fmt=%0b tag=%h ch=%h rate=%h",
							" / got wave=%0b fmt=%0b tag=%h ch=%h rate=%h"},
							want_res.is_wave, want_res.fmt_found, want_res.fmt_code,
							want_res.channel_count, want_res.rate_hz,
							seen_res.is_wave, seen_res.fmt_found, seen_res.fmt_code,
							seen_res.channel_count, seen_res.rate_hz);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int random_bytes;
		errors = 0;
		idle_pct = 25;
		stall_pct = 75;
		random_bytes = 0;
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.payload_byte = 8'h0;
		byte_ch.last_byte = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (wav_cases[i]) begin
			build_case(wav_cases[i]);
			send_payload(wav_cases[i].known, wav_cases[i].exp);
		end

		while (random_bytes < 500) begin
			if (random_bytes < 170) begin
				idle_pct = 25;
				stall_pct = 75;
			end else if (random_bytes < 340) begin
				idle_pct = 75;
				stall_pct = 25;
			end else begin
				idle_pct = 0;
				stall_pct = 0;
			end
			make_random_payload();
			random_bytes += payload.size();
			send_payload(1'b0, NOT_WAV);
		end
		byte_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== riff_wave_format_sniffer_unit.f =====
hdl/rwfs_pkg.sv
hdl/rwfs_byte_if.sv
hdl/rwfs_result_if.sv
hdl/rwfs_parser.sv
hdl/riff_wave_format_sniffer_unit.sv
test/riff_wave_format_sniffer_unit_tb.sv
